FILE: hdl/assert_macros.svh
// assertion macros shared by the checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked assertion, off while reset is held
`define TW_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  prop) else $error(msg);
// clocked assertion, also checked during reset
`define TW_ASSERT_RST(lbl, prop, msg) lbl: assert property (@(posedge clk) prop) \
  else $error(msg);
`endif

FILE: hdl/twpws_pkg.sv
// ----------------------------------------------------------------------------
// twpws_pkg
// shared widths, register codes and the block record type
// ----------------------------------------------------------------------------
package twpws_pkg;

  localparam int NPH         = 3;
  localparam int SAMPLE_W    = 16;
  localparam int MAX_SAMPLES = 4096;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = SAMPLE_W + CNT_W - 1;
  localparam int SQ_W        = 2 * SAMPLE_W + CNT_W - 2;
  localparam int LIM_W       = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int PH_W        = 2;

  // n * sumsq is built from two narrower partial products
  localparam int MUL_SPLIT = (SQ_W + 1) / 2;
  localparam int LO_W      = CNT_W + MUL_SPLIT;
  localparam int HI_W      = CNT_W + SQ_W - MUL_SPLIT;
  localparam int NUM_W     = 2 * SUM_W;
  localparam int DIV_D_W   = 2 * CNT_W - 1;
  localparam int VAR_W     = 31;
  localparam int SQRT_IN_W = 32;
  localparam int ROOT_W    = 16;

  localparam int FIFO_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RMS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RMS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_THR = 2'd2;

  localparam logic [LIM_W-1:0] RST_RMS_LOW  = 15'd6624;
  localparam logic [LIM_W-1:0] RST_RMS_HIGH = 15'd8096;
  localparam logic [LIM_W-1:0] RST_CLIP_THR = 15'd10397;

  localparam logic [PH_W-1:0] PH_LAST = 2'd2;

  typedef struct packed {
    logic [NPH-1:0][SUM_W-1:0]    sum;
    logic [NPH-1:0][SQ_W-1:0]     sq;
    logic [NPH-1:0][SAMPLE_W-1:0] maxv;
    logic [NPH-1:0][SAMPLE_W-1:0] minv;
    logic [NPH-1:0]               clip;
    logic [CNT_W-1:0]             cnt;
    logic                         ovf;
  } blk_rec_t;

  typedef struct packed {
    logic [LIM_W-1:0] low;
    logic [LIM_W-1:0] high;
  } rms_lim_t;

endpackage

FILE: hdl/twpws_div.sv
// ----------------------------------------------------------------------------
// twpws_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module twpws_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [twpws_pkg::NUM_W-1:0]        dvd,
  input  logic [twpws_pkg::DIV_D_W-1:0]      dvs,
  output logic                               done,
  output logic [twpws_pkg::NUM_W-1:0]        quot,
  output logic [twpws_pkg::DIV_D_W-1:0]      rem
);
  localparam int CW = $clog2(twpws_pkg::NUM_W);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [CW-1:0]                     cnt_r, cnt_nxt;
  logic [twpws_pkg::NUM_W-1:0]       q_r, q_nxt;
  logic [twpws_pkg::DIV_D_W-1:0]     rem_r, rem_nxt;
  logic [twpws_pkg::DIV_D_W-1:0]     dvs_r, dvs_nxt;
  logic [twpws_pkg::DIV_D_W:0]       sh;
  logic                              ge;

  always_comb begin
    sh       = {rem_r, q_r[twpws_pkg::NUM_W-1]};
    ge       = (sh >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(twpws_pkg::NUM_W - 1);
      q_nxt    = dvd;
      rem_nxt  = '0;
      dvs_nxt  = dvs;
    end else if (busy_r) begin
      rem_nxt = ge ? twpws_pkg::DIV_D_W'(sh - {1'b0, dvs_r})
                   : twpws_pkg::DIV_D_W'(sh);
      q_nxt   = {q_r[twpws_pkg::NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;
endmodule

FILE: hdl/twpws_sqrt.sv
// ----------------------------------------------------------------------------
// twpws_sqrt
// floor square root, one root bit per cycle
// ----------------------------------------------------------------------------
module twpws_sqrt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [twpws_pkg::SQRT_IN_W-1:0]    x,
  output logic                               done,
  output logic [twpws_pkg::ROOT_W-1:0]       root
);
  localparam int CW = $clog2(twpws_pkg::ROOT_W);
  localparam int RW = twpws_pkg::ROOT_W + 1;

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [CW-1:0]                      cnt_r, cnt_nxt;
  logic [twpws_pkg::SQRT_IN_W-1:0]    x_r, x_nxt;
  logic [RW-1:0]                      rem_r, rem_nxt;
  logic [twpws_pkg::ROOT_W-1:0]       root_r, root_nxt;
  logic [RW+1:0]                      rsh;
  logic [RW+1:0]                      trial;
  logic                               ge;

  always_comb begin
    rsh      = {rem_r, x_r[twpws_pkg::SQRT_IN_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    ge       = (rsh >= trial);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(twpws_pkg::ROOT_W - 1);
      x_nxt    = x;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? RW'(rsh - trial) : RW'(rsh);
      root_nxt = {root_r[twpws_pkg::ROOT_W-2:0], ge};
      x_nxt    = {x_r[twpws_pkg::SQRT_IN_W-3:0], 2'b00};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule

FILE: hdl/twpws_fifo.sv
// ----------------------------------------------------------------------------
// twpws_fifo
// short queue of finished block records between front and back
// ----------------------------------------------------------------------------
module twpws_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  twpws_pkg::blk_rec_t   wr_rec,
  input  logic                  pop,
  output twpws_pkg::blk_rec_t   rd_rec,
  output logic                  full,
  output logic                  empty
);
  localparam int PW = $clog2(twpws_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(twpws_pkg::FIFO_DEPTH + 1);

  twpws_pkg::blk_rec_t   ent_r [twpws_pkg::FIFO_DEPTH];
  logic [PW-1:0]         wp_r, rp_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wp_r] <= wr_rec;
    end
  end

  assign rd_rec = ent_r[rp_r];
  assign full   = (cnt_r == CW'(twpws_pkg::FIFO_DEPTH));
  assign empty  = (cnt_r == '0);
endmodule

FILE: hdl/twpws_front.sv
// ----------------------------------------------------------------------------
// twpws_front
// per-sample accumulation of sums, squares, extremes and clip flags
// ----------------------------------------------------------------------------
module twpws_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [twpws_pkg::SAMPLE_W-1:0] in_phase_a_sample,
  input  logic signed [twpws_pkg::SAMPLE_W-1:0] in_phase_b_sample,
  input  logic signed [twpws_pkg::SAMPLE_W-1:0] in_phase_c_sample,
  input  logic                                 in_last_sample,
  input  logic [twpws_pkg::LIM_W-1:0]          clip_thr,
  input  logic                                 q_full,
  output logic                                 push,
  output twpws_pkg::blk_rec_t                  push_rec
);
  twpws_pkg::blk_rec_t acc_r, acc_nxt, upd, blk;
  logic signed [twpws_pkg::SAMPLE_W-1:0]  s   [twpws_pkg::NPH];
  logic signed [2*twpws_pkg::SAMPLE_W-1:0] sq2 [twpws_pkg::NPH];
  logic [twpws_pkg::SAMPLE_W:0]           mag [twpws_pkg::NPH];
  logic                                   take, keep;

  assign s[0] = in_phase_a_sample;
  assign s[1] = in_phase_b_sample;
  assign s[2] = in_phase_c_sample;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign keep     = (acc_r.cnt < twpws_pkg::CNT_W'(twpws_pkg::MAX_SAMPLES));

  always_comb begin
    upd = acc_r;
    for (int p = 0; p < twpws_pkg::NPH; p++) begin
      sq2[p] = s[p] * s[p];
      mag[p] = s[p][twpws_pkg::SAMPLE_W-1]
             ? (twpws_pkg::SAMPLE_W+1)'(-(twpws_pkg::SAMPLE_W+1)'(s[p]))
             : (twpws_pkg::SAMPLE_W+1)'(s[p]);
      upd.sum[p] = acc_r.sum[p] + twpws_pkg::SUM_W'(s[p]);
      upd.sq[p]  = acc_r.sq[p] + twpws_pkg::SQ_W'(unsigned'(sq2[p]));
      if (s[p] > signed'(acc_r.maxv[p])) begin
        upd.maxv[p] = s[p];
      end
      if (s[p] < signed'(acc_r.minv[p])) begin
        upd.minv[p] = s[p];
      end
      if (mag[p] >= (twpws_pkg::SAMPLE_W+1)'(clip_thr)) begin
        upd.clip[p] = 1'b1;
      end
    end
    upd.cnt = acc_r.cnt + 1'b1;

    blk = acc_r;
    if (keep) begin
      blk = upd;
    end else begin
      blk.ovf = 1'b1;
    end

    acc_nxt = acc_r;
    if (take) begin
      acc_nxt = in_last_sample ? '0 : blk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign push     = take && in_last_sample;
  assign push_rec = blk;
endmodule

FILE: hdl/twpws_back.sv
// ----------------------------------------------------------------------------
// twpws_back
// end-of-block sequencer: divisions, square roots and result register
// ----------------------------------------------------------------------------
module twpws_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_empty,
  output logic                                  pop,
  input  twpws_pkg::blk_rec_t                   rec,
  input  twpws_pkg::rms_lim_t                   lim,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [twpws_pkg::PH_W-1:0]            out_phase_index,
  output logic [twpws_pkg::ROOT_W-1:0]          out_rms_value,
  output logic signed [twpws_pkg::SAMPLE_W-1:0] out_mean_value,
  output logic [twpws_pkg::SAMPLE_W-1:0]        out_peak_to_peak,
  output logic [twpws_pkg::VAR_W-1:0]           out_variance_value,
  output logic [twpws_pkg::ROOT_W-1:0]          out_std_deviation,
  output logic                                  out_rms_compliant,
  output logic                                  out_clipping_seen,
  output logic                                  out_block_overflowed,
  output logic                                  out_last_result
);
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_MUL0  = 10'b0000000010,
    ST_MUL1  = 10'b0000000100,
    ST_NUM   = 10'b0000001000,
    ST_DSQ   = 10'b0000010000,
    ST_RMS   = 10'b0000100000,
    ST_DMEAN = 10'b0001000000,
    ST_DVAR  = 10'b0010000000,
    ST_DEV   = 10'b0100000000,
    ST_EMIT  = 10'b1000000000
  } bk_state_t;

  localparam int SW = twpws_pkg::SAMPLE_W;

  bk_state_t                          state_r, state_nxt;
  twpws_pkg::blk_rec_t                rec_r;
  logic [twpws_pkg::PH_W-1:0]         ph_r;
  logic [twpws_pkg::LO_W-1:0]         mlo_r;
  logic [twpws_pkg::HI_W-1:0]         mhi_r;
  logic [twpws_pkg::NUM_W-1:0]        asq_r, num_r;
  logic [twpws_pkg::DIV_D_W-1:0]      nn_r;
  logic [twpws_pkg::ROOT_W-1:0]       rms_r, dev_r;
  logic signed [SW-1:0]               mean_r;
  logic [twpws_pkg::VAR_W-1:0]        var_r;

  logic                               out_valid_r;
  logic [twpws_pkg::PH_W-1:0]         o_ph_r;
  logic [twpws_pkg::ROOT_W-1:0]       o_rms_r, o_dev_r;
  logic signed [SW-1:0]               o_mean_r;
  logic [SW-1:0]                      o_p2p_r;
  logic [twpws_pkg::VAR_W-1:0]        o_var_r;
  logic                               o_ok_r, o_clip_r, o_ovf_r, o_last_r;

  logic signed [twpws_pkg::SUM_W-1:0] sum_s;
  logic [twpws_pkg::SUM_W-1:0]        asum;
  logic [twpws_pkg::SQ_W-1:0]         sq;
  logic [twpws_pkg::CNT_W-1:0]        n;
  logic                               nz;
  logic                               out_free, load;
  logic [SW:0]                        qm, qa;
  logic [twpws_pkg::ROOT_W-1:0]       rms_f, dev_f;
  logic signed [SW-1:0]               mean_f;
  logic [twpws_pkg::VAR_W-1:0]        var_f;
  logic signed [SW:0]                 p2p_w;

  logic                               div_start, div_done;
  logic [twpws_pkg::NUM_W-1:0]        div_a, div_q;
  logic [twpws_pkg::DIV_D_W-1:0]      div_b, div_r;
  logic                               sqr_start, sqr_done;
  logic [twpws_pkg::SQRT_IN_W-1:0]    sqr_x;
  logic [twpws_pkg::ROOT_W-1:0]       sqr_root;

  twpws_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_a),
    .dvs   (div_b),
    .done  (div_done),
    .quot  (div_q),
    .rem   (div_r)
  );

  twpws_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqr_start),
    .x     (sqr_x),
    .done  (sqr_done),
    .root  (sqr_root)
  );

  always_comb begin
    sum_s    = signed'(rec_r.sum[ph_r]);
    asum     = sum_s[twpws_pkg::SUM_W-1] ? twpws_pkg::SUM_W'(-sum_s)
                                         : twpws_pkg::SUM_W'(sum_s);
    sq       = rec_r.sq[ph_r];
    n        = rec_r.cnt;
    nz       = (n == '0);
    out_free = !out_valid_r || out_ready;
    qm       = div_q[SW:0];
    qa       = qm + (SW+1)'(div_r != '0);
    // empty block reports zeros
    rms_f    = nz ? '0 : rms_r;
    dev_f    = nz ? '0 : dev_r;
    mean_f   = nz ? '0 : mean_r;
    var_f    = nz ? '0 : var_r;
    p2p_w    = (SW+1)'(signed'(rec_r.maxv[ph_r])) - (SW+1)'(signed'(rec_r.minv[ph_r]));

    state_nxt = state_r;
    pop       = 1'b0;
    load      = 1'b0;
    div_start = 1'b0;
    div_a     = twpws_pkg::NUM_W'(sq);
    div_b     = twpws_pkg::DIV_D_W'(n);
    sqr_start = 1'b0;
    sqr_x     = twpws_pkg::SQRT_IN_W'(div_q);
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          state_nxt = ST_MUL0;
        end
      end
      ST_MUL0: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_NUM;
      ST_NUM: begin
        div_start = 1'b1;
        state_nxt = ST_DSQ;
      end
      ST_DSQ: begin
        if (div_done) begin
          sqr_start = 1'b1;
          state_nxt = ST_RMS;
        end
      end
      ST_RMS: begin
        if (sqr_done) begin
          div_start = 1'b1;
          div_a     = twpws_pkg::NUM_W'(asum);
          state_nxt = ST_DMEAN;
        end
      end
      ST_DMEAN: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = num_r;
          div_b     = nn_r;
          state_nxt = ST_DVAR;
        end
      end
      ST_DVAR: begin
        if (div_done) begin
          sqr_start = 1'b1;
          sqr_x     = twpws_pkg::SQRT_IN_W'(div_q[twpws_pkg::VAR_W-1:0]);
          state_nxt = ST_DEV;
        end
      end
      ST_DEV: begin
        if (sqr_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = (ph_r == twpws_pkg::PH_LAST) ? ST_IDLE : ST_MUL0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        ph_r <= '0;
      end else if (load) begin
        ph_r <= ph_r + 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (pop) begin
      rec_r <= rec;
    end
    if (state_r == ST_MUL0) begin
      mlo_r <= twpws_pkg::LO_W'(n * sq[twpws_pkg::MUL_SPLIT-1:0]);
      asq_r <= twpws_pkg::NUM_W'(asum * asum);
      nn_r  <= twpws_pkg::DIV_D_W'(n * n);
    end
    if (state_r == ST_MUL1) begin
      mhi_r <= twpws_pkg::HI_W'(n * sq[twpws_pkg::SQ_W-1:twpws_pkg::MUL_SPLIT]);
    end
    if (state_r == ST_NUM) begin
      // n*sumsq - sum^2
      num_r <= twpws_pkg::NUM_W'(mlo_r)
             + (twpws_pkg::NUM_W'(mhi_r) << twpws_pkg::MUL_SPLIT) - asq_r;
    end
    if (state_r == ST_RMS && sqr_done) begin
      rms_r <= sqr_root;
    end
    if (state_r == ST_DMEAN && div_done) begin
      mean_r <= sum_s[twpws_pkg::SUM_W-1] ? SW'(-qa) : SW'(qm);
    end
    if (state_r == ST_DVAR && div_done) begin
      var_r <= div_q[twpws_pkg::VAR_W-1:0];
    end
    if (state_r == ST_DEV && sqr_done) begin
      dev_r <= sqr_root;
    end
    if (load) begin
      o_ph_r   <= ph_r;
      o_rms_r  <= rms_f;
      o_mean_r <= mean_f;
      o_p2p_r  <= p2p_w[SW-1:0];
      o_var_r  <= var_f;
      o_dev_r  <= dev_f;
      o_ok_r   <= (rms_f >= twpws_pkg::ROOT_W'(lim.low))
               && (rms_f <= twpws_pkg::ROOT_W'(lim.high));
      o_clip_r <= rec_r.clip[ph_r];
      o_ovf_r  <= rec_r.ovf;
      o_last_r <= (ph_r == twpws_pkg::PH_LAST);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_phase_index      = o_ph_r;
  assign out_rms_value        = o_rms_r;
  assign out_mean_value       = o_mean_r;
  assign out_peak_to_peak     = o_p2p_r;
  assign out_variance_value   = o_var_r;
  assign out_std_deviation    = o_dev_r;
  assign out_rms_compliant    = o_ok_r;
  assign out_clipping_seen    = o_clip_r;
  assign out_block_overflowed = o_ovf_r;
  assign out_last_result      = o_last_r;
endmodule

FILE: hdl/three_phase_waveform_statistics.sv
// ----------------------------------------------------------------------------
// three_phase_waveform_statistics
// per-phase mean, rms, peak-to-peak, variance and deviation of sample blocks
// ----------------------------------------------------------------------------
// usage
//   input beat: one signed sample per phase plus a last-of-block flag, taken
//   on in_valid & in_ready. the front accumulates one beat per cycle; in_ready
//   drops only while the record queue (two blocks deep) is full.
//   output beat: three beats per block, phases a, b, c in order, last_result
//   set on phase c. each result holds in the output register until taken.
//   processing: each phase runs through the shared one-bit-per-cycle divider
//   (three 56-step divisions per phase) and the 16-step square root unit;
//   blocks that arrive faster than the back can finish them back up in the
//   queue.
//   samples past 4096 in a block are dropped and block_overflowed is set.
//   config: cfg_wr_en with cfg_index 0 low rms limit, 1 high limit, 2 clip
//   threshold; write only while idle.
//   reset: synchronous, active low; clears accumulators, queue, sequencer and
//   output valid, and restores the default limits.
//   stalls: a low out_ready stops the back at its emit state; the front keeps
//   taking beats until the queue fills.
// ----------------------------------------------------------------------------
module three_phase_waveform_statistics (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [twpws_pkg::SAMPLE_W-1:0] in_phase_a_sample,
  input  logic signed [twpws_pkg::SAMPLE_W-1:0] in_phase_b_sample,
  input  logic signed [twpws_pkg::SAMPLE_W-1:0] in_phase_c_sample,
  input  logic                                  in_last_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [twpws_pkg::PH_W-1:0]            out_phase_index,
  output logic [twpws_pkg::ROOT_W-1:0]          out_rms_value,
  output logic signed [twpws_pkg::SAMPLE_W-1:0] out_mean_value,
  output logic [twpws_pkg::SAMPLE_W-1:0]        out_peak_to_peak,
  output logic [twpws_pkg::VAR_W-1:0]           out_variance_value,
  output logic [twpws_pkg::ROOT_W-1:0]          out_std_deviation,
  output logic                                  out_rms_compliant,
  output logic                                  out_clipping_seen,
  output logic                                  out_block_overflowed,
  output logic                                  out_last_result,
  input  logic                                  cfg_wr_en,
  input  logic [twpws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [twpws_pkg::LIM_W-1:0]           cfg_wdata
);
  // configuration registers
  logic [twpws_pkg::LIM_W-1:0] rms_low_r, rms_high_r, clip_thr_r;
  twpws_pkg::rms_lim_t         lim;

  // queue between front and back
  logic                        q_push, q_pop, q_full, q_empty;
  twpws_pkg::blk_rec_t         q_wr_rec, q_rd_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rms_low_r  <= twpws_pkg::RST_RMS_LOW;
      rms_high_r <= twpws_pkg::RST_RMS_HIGH;
      clip_thr_r <= twpws_pkg::RST_CLIP_THR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        twpws_pkg::CFG_RMS_LOW:  rms_low_r  <= cfg_wdata;
        twpws_pkg::CFG_RMS_HIGH: rms_high_r <= cfg_wdata;
        twpws_pkg::CFG_CLIP_THR: clip_thr_r <= cfg_wdata;
        default: ;  // unused index is ignored
      endcase
    end
  end

  assign lim.low  = rms_low_r;
  assign lim.high = rms_high_r;

  // front: one beat per cycle into the accumulators while the queue is not full
  twpws_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_phase_a_sample (in_phase_a_sample),
    .in_phase_b_sample (in_phase_b_sample),
    .in_phase_c_sample (in_phase_c_sample),
    .in_last_sample    (in_last_sample),
    .clip_thr          (clip_thr_r),
    .q_full            (q_full),
    .push              (q_push),
    .push_rec          (q_wr_rec)
  );

  twpws_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_rec (q_wr_rec),
    .pop    (q_pop),
    .rd_rec (q_rd_rec),
    .full   (q_full),
    .empty  (q_empty)
  );

  // back: per-phase statistics and the result register
  twpws_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .pop                  (q_pop),
    .rec                  (q_rd_rec),
    .lim                  (lim),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_phase_index      (out_phase_index),
    .out_rms_value        (out_rms_value),
    .out_mean_value       (out_mean_value),
    .out_peak_to_peak     (out_peak_to_peak),
    .out_variance_value   (out_variance_value),
    .out_std_deviation    (out_std_deviation),
    .out_rms_compliant    (out_rms_compliant),
    .out_clipping_seen    (out_clipping_seen),
    .out_block_overflowed (out_block_overflowed),
    .out_last_result      (out_last_result)
  );
endmodule

FILE: hdl/twpws_checker.sv
// ----------------------------------------------------------------------------
// twpws_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twpws_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [twpws_pkg::PH_W-1:0]            out_phase_index,
  input  logic [twpws_pkg::ROOT_W-1:0]          out_rms_value,
  input  logic                                  out_rms_compliant,
  input  logic                                  out_last_result
);
  // stalled result beat holds
  `TW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_rms_value) && $stable(out_phase_index), "result beat changed while stalled")
  // last flag marks phase c only
  `TW_ASSERT(a_last_ph, out_valid |-> (out_last_result == (out_phase_index == twpws_pkg::PH_LAST)), "last flag off phase c")
  // limits are 15 bit, so a compliant rms has a clear top bit
  `TW_ASSERT(a_ok_range, out_valid && out_rms_compliant |-> !out_rms_value[twpws_pkg::ROOT_W-1], "compliant rms out of limit range")
  // reset empties the result register
  `TW_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")
endmodule

bind three_phase_waveform_statistics twpws_checker u_twpws_checker (.*);
